>>> rtl/core/dvr_pkg.sv
// dvr_pkg: types and constants shared by the distance-vector router
// no dependencies
`default_nettype none
package dvr_pkg;
    localparam int COST_W = 21;
    localparam int IDX_W  = 3;
    localparam int HOP_W  = 4;
    localparam int CNT_W  = 4;
    localparam int SLOTS  = 8;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = SLOTS * SLOTS;

    localparam logic signed [COST_W-1:0] COST_NONE = '1;
    localparam logic signed [COST_W-1:0] COST_ZERO = '0;
    localparam logic signed [COST_W-1:0] COST_MAX  = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN  = {1'b1, {(COST_W-1){1'b0}}};
    localparam logic signed [HOP_W-1:0]  HOP_NONE  = '1;

    typedef enum logic [1:0] {
        CMD_LINK = 2'd0,
        CMD_VEC  = 2'd1,
        CMD_CHG  = 2'd2,
        CMD_QRY  = 2'd3
    } cmd_t;

    localparam logic KIND_ADV = 1'b0;
    localparam logic KIND_ANS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_IA_N,
        ST_IA_J,
        ST_RC_T,
        ST_RC_RD,
        ST_RC_FIN,
        ST_ADV_N,
        ST_ADV_RD,
        ST_ADV_OUT,
        ST_QRY
    } state_t;
endpackage
`default_nettype wire

>>> rtl/core/distance_vector_router_top.sv
// distance_vector_router_top: distance-vector router, bellman-ford with poison reverse
// depends on dvr_pkg and dvr_ram (cost table memory, 8x8 entries)
// a query is answered from the hop table; a recompute reads each target's cost via every
// neighbour and advertises every entry if a route changed; a rebuild writes the link row,
// then sends link costs to neighbours; input is taken only when idle, one command at a time
// reset: tables take their reset values at once through per-entry valid bits
`default_nettype none
module distance_vector_router_top #(
    parameter int NODES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_data,      // my_node
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // node[2:0], source[5:3], cost[26:6]
    input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
    input  wire logic        s_axis_tlast,  // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // dest_nbr[2:0], entry_target[5:3],
                                            // entry_cost[26:6], route_hop[30:27],
                                            // packet_end[31]
    output logic [0:0]       m_axis_tuser,  // kind
    output logic             m_axis_tlast   // run_last
);
    import dvr_pkg::*;

    localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] my_reg;
    logic signed [COST_W-1:0] link_reg [SLOTS];
    logic signed [COST_W-1:0] link_next [SLOTS];
    logic signed [HOP_W-1:0]  hop_reg [SLOTS];
    logic signed [HOP_W-1:0]  hop_next [SLOTS];
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic [CNT_W-1:0] t_reg, t_next, k_reg, k_next, n_reg, n_next, i_reg, i_next;
    logic [CNT_W-1:0] kd_reg, kd_next;
    logic pipe_reg, pipe_next;
    logic found_reg, found_next, changed_reg, changed_next;
    logic signed [COST_W-1:0] best_reg, best_next;
    logic signed [HOP_W-1:0]  bhop_reg, bhop_next;
    logic [IDX_W-1:0] qnode_reg, qnode_next;

    logic out_valid_reg;
    logic out_kind_reg, out_pend_reg, out_last_reg;
    logic [IDX_W-1:0] out_dest_reg, out_tgt_reg;
    logic signed [COST_W-1:0] out_cost_reg;
    logic signed [HOP_W-1:0]  out_hop_reg;

    logic emit, e_kind, e_pend, e_last;
    logic [IDX_W-1:0] e_dest, e_tgt;
    logic signed [COST_W-1:0] e_cost;
    logic signed [HOP_W-1:0]  e_hop;

    logic we, re;
    logic [ADDR_W-1:0] waddr, raddr, rd_addr_reg;
    logic [COST_W-1:0] wdata, rdata;
    logic rd_vld_reg;
    logic signed [COST_W-1:0] eff;
    logic [SLOTS-1:0] neigh;
    logic ofree, in_acc;
    logic [IDX_W-1:0] in_node, in_src;
    logic signed [COST_W-1:0] in_cost;
    logic signed [COST_W:0] sum;
    logic signed [COST_W-1:0] sat;

    dvr_ram #(.WIDTH(COST_W), .DEPTH(DEPTH)) u_cost (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_node       = s_axis_tdata[2:0];
    assign in_src        = s_axis_tdata[5:3];
    assign in_cost       = s_axis_tdata[26:6];
    assign ofree         = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_pend_reg, out_hop_reg, out_cost_reg, out_tgt_reg, out_dest_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            neigh[j] = (j < NODES) && (link_reg[j] != COST_NONE)
                       && (my_reg != IDX_W'(j));
        end
    end

    // unwritten entries read as their reset value
    assign eff = rd_vld_reg ? $signed(rdata)
               : ((rd_addr_reg[ADDR_W-1:IDX_W] == rd_addr_reg[IDX_W-1:0]) ? COST_ZERO
                                                                           : COST_NONE);

    assign sum = $signed({link_reg[kd_reg[IDX_W-1:0]][COST_W-1], link_reg[kd_reg[IDX_W-1:0]]})
               + $signed({eff[COST_W-1], eff});
    always_comb
    begin
        if (sum > $signed({COST_MAX[COST_W-1], COST_MAX}))
        begin
            sat = COST_MAX;
        end
        else if (sum < $signed({COST_MIN[COST_W-1], COST_MIN}))
        begin
            sat = COST_MIN;
        end
        else
        begin
            sat = sum[COST_W-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        link_next    = link_reg;
        hop_next     = hop_reg;
        vld_next     = vld_reg;
        t_next       = t_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        kd_next      = kd_reg;
        pipe_next    = 1'b0;
        found_next   = found_reg;
        changed_next = changed_reg;
        best_next    = best_reg;
        bhop_next    = bhop_reg;
        qnode_next   = qnode_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        re = 1'b0;
        raddr = '0;
        emit = 1'b0;
        e_kind = KIND_ADV;
        e_dest = '0;
        e_tgt = '0;
        e_cost = COST_ZERO;
        e_hop = '0;
        e_pend = 1'b0;
        e_last = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd_t'(s_axis_tuser))
                        CMD_LINK:
                        begin
                            if ({1'b0, in_node} < NODES_C)
                            begin
                                link_next[in_node] = in_cost;
                            end
                            if (s_axis_tlast)
                            begin
                                vld_next = '0;
                                for (int j = 0; j < SLOTS; j++)
                                begin
                                    hop_next[j] = HOP_NONE;
                                end
                                i_next = '0;
                                state_next = ST_INIT;
                            end
                        end
                        CMD_VEC:
                        begin
                            if ({1'b0, in_node} < NODES_C && {1'b0, in_src} < NODES_C)
                            begin
                                we = 1'b1;
                                waddr = {in_src, in_node};
                                wdata = in_cost;
                                vld_next[{in_src, in_node}] = 1'b1;
                            end
                            if (s_axis_tlast)
                            begin
                                t_next = '0;
                                changed_next = 1'b0;
                                state_next = ST_RC_T;
                            end
                        end
                        CMD_CHG:
                        begin
                            if ({1'b0, in_node} < NODES_C)
                            begin
                                link_next[in_node] = in_cost;
                            end
                            t_next = '0;
                            changed_next = 1'b0;
                            state_next = ST_RC_T;
                        end
                        default:
                        begin
                            qnode_next = in_node;
                            state_next = ST_QRY;
                        end
                    endcase
                end
            end
            ST_INIT:
            begin
                if (i_reg == NODES_C)
                begin
                    n_next = '0;
                    state_next = ST_IA_N;
                end
                else
                begin
                    if (link_reg[i_reg[IDX_W-1:0]] != COST_NONE)
                    begin
                        we = 1'b1;
                        waddr = {my_reg, i_reg[IDX_W-1:0]};
                        wdata = link_reg[i_reg[IDX_W-1:0]];
                        vld_next[{my_reg, i_reg[IDX_W-1:0]}] = 1'b1;
                        hop_next[i_reg[IDX_W-1:0]] = HOP_W'(i_reg);
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            ST_IA_N:
            begin
                if (n_reg == NODES_C)
                begin
                    state_next = ST_IDLE;
                end
                else if (neigh[n_reg[IDX_W-1:0]])
                begin
                    i_next = '0;
                    state_next = ST_IA_J;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                end
            end
            ST_IA_J:
            begin
                if (i_reg == NODES_C)
                begin
                    n_next = n_reg + 1'b1;
                    state_next = ST_IA_N;
                end
                else if (!neigh[i_reg[IDX_W-1:0]])
                begin
                    i_next = i_reg + 1'b1;
                end
                else if (ofree)
                begin
                    emit = 1'b1;
                    e_dest = n_reg[IDX_W-1:0];
                    e_tgt = i_reg[IDX_W-1:0];
                    e_cost = link_reg[i_reg[IDX_W-1:0]];
                    e_pend = (neigh & (8'hFE << i_reg[IDX_W-1:0])) == '0;
                    e_last = e_pend && ((neigh & (8'hFE << n_reg[IDX_W-1:0])) == '0);
                    i_next = i_reg + 1'b1;
                end
            end
            ST_RC_T:
            begin
                if (t_reg == NODES_C)
                begin
                    n_next = '0;
                    state_next = changed_reg ? ST_ADV_N : ST_IDLE;
                end
                else if (t_reg == {1'b0, my_reg})
                begin
                    t_next = t_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    found_next = 1'b0;
                    best_next = COST_NONE;
                    bhop_next = HOP_NONE;
                    state_next = ST_RC_RD;
                end
            end
            ST_RC_RD:
            begin
                if (pipe_reg && neigh[kd_reg[IDX_W-1:0]] && eff != COST_NONE
                    && (!found_reg || sat < best_reg))
                begin
                    found_next = 1'b1;
                    best_next = sat;
                    bhop_next = HOP_W'(kd_reg);
                end
                re = 1'b1;
                raddr = (k_reg == NODES_C) ? {my_reg, t_reg[IDX_W-1:0]}
                                           : {k_reg[IDX_W-1:0], t_reg[IDX_W-1:0]};
                kd_next = k_reg;
                pipe_next = (k_reg != NODES_C);
                if (k_reg == NODES_C)
                begin
                    state_next = ST_RC_FIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_RC_FIN:
            begin
                if (best_reg != eff)
                begin
                    we = 1'b1;
                    waddr = {my_reg, t_reg[IDX_W-1:0]};
                    wdata = best_reg;
                    vld_next[{my_reg, t_reg[IDX_W-1:0]}] = 1'b1;
                    hop_next[t_reg[IDX_W-1:0]] = bhop_reg;
                    changed_next = 1'b1;
                end
                t_next = t_reg + 1'b1;
                state_next = ST_RC_T;
            end
            ST_ADV_N:
            begin
                if (n_reg == NODES_C)
                begin
                    state_next = ST_IDLE;
                end
                else if (neigh[n_reg[IDX_W-1:0]])
                begin
                    i_next = '0;
                    state_next = ST_ADV_RD;
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                end
            end
            ST_ADV_RD:
            begin
                re = 1'b1;
                raddr = {my_reg, i_reg[IDX_W-1:0]};
                state_next = ST_ADV_OUT;
            end
            ST_ADV_OUT:
            begin
                if (ofree)
                begin
                    emit = 1'b1;
                    e_dest = n_reg[IDX_W-1:0];
                    e_tgt = i_reg[IDX_W-1:0];
                    // poison reverse
                    e_cost = (hop_reg[i_reg[IDX_W-1:0]] == HOP_W'(n_reg)) ? COST_NONE : eff;
                    e_pend = (i_reg == NODES_C - 1'b1);
                    e_last = e_pend && ((neigh & (8'hFE << n_reg[IDX_W-1:0])) == '0);
                    if (e_pend)
                    begin
                        n_next = n_reg + 1'b1;
                        state_next = ST_ADV_N;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = ST_ADV_RD;
                    end
                end
            end
            ST_QRY:
            begin
                if (ofree)
                begin
                    emit = 1'b1;
                    e_kind = KIND_ANS;
                    e_hop = ({1'b0, qnode_reg} < NODES_C) ? hop_reg[qnode_reg] : HOP_NONE;
                    e_last = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            my_reg        <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            pipe_reg      <= 1'b0;
            found_reg     <= 1'b0;
            changed_reg   <= 1'b0;
            t_reg         <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            kd_reg        <= '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                link_reg[j] <= COST_NONE;
                hop_reg[j]  <= HOP_NONE;
            end
        end
        else
        begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            link_reg    <= link_next;
            hop_reg     <= hop_next;
            pipe_reg    <= pipe_next;
            found_reg   <= found_next;
            changed_reg <= changed_next;
            t_reg       <= t_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            kd_reg      <= kd_next;
            if (cfg_valid && cfg_ready)
            begin
                my_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        bhop_reg  <= bhop_next;
        qnode_reg <= qnode_next;
        if (re)
        begin
            rd_addr_reg <= raddr;
            rd_vld_reg  <= vld_reg[raddr];
        end
        if (emit)
        begin
            out_kind_reg <= e_kind;
            out_dest_reg <= e_dest;
            out_tgt_reg  <= e_tgt;
            out_cost_reg <= e_cost;
            out_hop_reg  <= e_hop;
            out_pend_reg <= e_pend;
            out_last_reg <= e_last;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/dvr_ram.sv
// dvr_ram: generic simple dual-port ram with registered read
// no dependencies
`default_nettype none
module dvr_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/dvr_route_checker.sv
// dvr_route_checker: watches the config, input and result channels of the router,
// predicts every result beat and compares it field by field; depends on dvr_pkg
`default_nettype none
module dvr_route_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic [0:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast,
    output int               fail_count,
    output int               beats_due,
    output int               beats_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import dvr_pkg::*;

    localparam int N = 8;

    typedef struct {
        logic                     kind;
        logic [2:0]               dest;
        logic [2:0]               target;
        logic signed [COST_W-1:0] cost;
        logic signed [HOP_W-1:0]  hop;
        logic                     pkt_end;
        logic                     run_end;
    } route_beat_t;

    route_beat_t              due_beats[$];
    logic signed [COST_W-1:0] link_cost[N];
    logic signed [COST_W-1:0] dist_tbl[N][N];
    logic signed [HOP_W-1:0]  hop_tbl[N];
    logic [2:0]               self_id;
    int                       n_caused;

    function automatic bit is_nbr(int j);
        return link_cost[j] != COST_NONE && j != int'(self_id);
    endfunction

    task automatic add_beat(logic kind, int dest, int target, logic signed [COST_W-1:0] cost,
                            logic signed [HOP_W-1:0] hop, logic pend);
        route_beat_t b;
        if (n_caused < 56)
        begin
            b.kind = kind;
            b.dest = dest[2:0];
            b.target = target[2:0];
            b.cost = cost;
            b.hop = hop;
            b.pkt_end = pend;
            b.run_end = 1'b0;
            due_beats.push_back(b);
            n_caused++;
        end
    endtask

    task automatic clear_tables();
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
                dist_tbl[i][j] = (i == j) ? COST_ZERO : COST_NONE;
            hop_tbl[i] = HOP_NONE;
        end
    endtask

    task automatic rebuild_routes();
        int last_nbr;
        clear_tables();
        for (int i = 0; i < N; i++)
            if (link_cost[i] != COST_NONE)
            begin
                dist_tbl[self_id][i] = link_cost[i];
                hop_tbl[i] = HOP_W'(i);
            end
        last_nbr = -1;
        for (int j = 0; j < N; j++)
            if (is_nbr(j))
                last_nbr = j;
        for (int n = 0; n < N; n++)
            if (is_nbr(n))
                for (int j = 0; j < N; j++)
                    if (is_nbr(j))
                        add_beat(KIND_ADV, n, j, link_cost[j], '0, j == last_nbr);
    endtask

    task automatic relax_routes();
        bit                       changed;
        bit                       found;
        int                       best;
        int                       best_hop;
        int                       s;
        logic signed [COST_W-1:0] c;
        changed = 0;
        for (int t = 0; t < N; t++)
        begin
            if (t == int'(self_id))
                continue;
            found = 0;
            best = -1;
            best_hop = -1;
            for (int n = 0; n < N; n++)
            begin
                if (!is_nbr(n) || dist_tbl[n][t] == COST_NONE)
                    continue;
                s = int'(link_cost[n]) + int'(dist_tbl[n][t]);
                if (s > int'(COST_MAX))
                    s = int'(COST_MAX);
                if (s < int'(COST_MIN))
                    s = int'(COST_MIN);
                if (!found || s < best)
                begin
                    found = 1;
                    best = s;
                    best_hop = n;
                end
            end
            if (COST_W'(best) != dist_tbl[self_id][t])
            begin
                dist_tbl[self_id][t] = COST_W'(best);
                hop_tbl[t] = HOP_W'(best_hop);
                changed = 1;
            end
        end
        if (changed)
            for (int n = 0; n < N; n++)
                if (is_nbr(n))
                    for (int i = 0; i < N; i++)
                    begin
                        c = (hop_tbl[i] == HOP_W'(n)) ? COST_NONE : dist_tbl[self_id][i];
                        add_beat(KIND_ADV, n, i, c, '0, i == N - 1);
                    end
    endtask

    task automatic route_step(cmd_t cmd, int nd, int src, logic signed [COST_W-1:0] cost,
                              logic lst);
        n_caused = 0;
        case (cmd)
            CMD_LINK:
            begin
                link_cost[nd] = cost;
                if (lst)
                    rebuild_routes();
            end
            CMD_VEC:
            begin
                dist_tbl[src][nd] = cost;
                if (lst)
                    relax_routes();
            end
            CMD_CHG:
            begin
                link_cost[nd] = cost;
                relax_routes();
            end
            default:
                add_beat(KIND_ANS, 0, 0, COST_ZERO, hop_tbl[nd], 1'b0);
        endcase
        if (n_caused > 0)
            due_beats[due_beats.size() - 1].run_end = 1'b1;
    endtask

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        beats_seen = 0;
        beats_due = 0;
    end

    always @(posedge clk)
    begin
        route_beat_t e;
        if (!rst_n)
        begin
            clear_tables();
            for (int i = 0; i < N; i++)
                link_cost[i] = COST_NONE;
            self_id = '0;
            due_beats.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                self_id = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_seen++;
                if (due_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    e = due_beats.pop_front();
                    check_field("kind", e.kind, m_axis_tuser[0]);
                    check_field("dest_nbr", e.dest, m_axis_tdata[2:0]);
                    check_field("entry_target", e.target, m_axis_tdata[5:3]);
                    check_field("entry_cost", e.cost, $signed(m_axis_tdata[26:6]));
                    check_field("route_hop", e.hop, $signed(m_axis_tdata[30:27]));
                    check_field("packet_end", e.pkt_end, m_axis_tdata[31]);
                    check_field("run_last", e.run_end, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                route_step(cmd_t'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[5:3],
                           $signed(s_axis_tdata[26:6]), s_axis_tlast);
        end
        beats_due = due_beats.size();
    end
endmodule
`default_nettype wire

>>> tb/sv/tb_distance_vector_router_top.sv
// tb_distance_vector_router_top: stimulus and verdict for the distance-vector router;
// depends on dvr_pkg, distance_vector_router_top and dvr_route_checker
`default_nettype none
module tb_distance_vector_router_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dvr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // node[2:0], source[5:3], cost[26:6]
    logic [1:0]  s_axis_tuser;   // cmd[1:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // dest_nbr[2:0], entry_target[5:3], entry_cost[26:6],
                                 // route_hop[30:27], packet_end[31]
    logic [0:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;

    int fail_count;
    int beats_due;
    int beats_seen;
    int items_sent;
    int phases_run;
    bit calm;

    distance_vector_router_top #(.NODES(8)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    dvr_route_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_count), .beats_due(beats_due), .beats_seen(beats_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, one long hold once the result backlog builds up
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && beats_due > 20)
            begin
                held = 1;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
        end
    end

    function automatic int pick_cost();
        case ($urandom_range(9))
            0, 1: return -1;
            2:    return 0;
            3:    return 1048575 - $urandom_range(3);
            4:    return $urandom_range(1048575);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    task automatic send(cmd_t cmd, int nd, int src, int cost, bit lst);
        logic [20:0] c21;
        c21 = cost[20:0];
        while (!calm && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, c21, src[2:0], nd[2:0]};
        s_axis_tuser <= cmd;
        s_axis_tlast <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // sender pauses until all results are back and the block has gone quiet
    task automatic settle();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (beats_due != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (150) @(posedge clk);
    endtask

    task automatic set_self(int id);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= id[2:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        phases_run++;
    endtask

    task automatic random_phase(int self_id);
        int n_links;
        int src;
        int n_ent;
        set_self(self_id);
        n_links = $urandom_range(1, 6);
        for (int i = 0; i < n_links; i++)
            send(CMD_LINK, $urandom_range(7), $urandom_range(7),
                 ($urandom_range(4) == 0) ? -1 : $urandom_range(1, 30), i == n_links - 1);
        repeat ($urandom_range(2, 4))
        begin
            src = $urandom_range(7);
            n_ent = $urandom_range(1, 5);
            for (int i = 0; i < n_ent; i++)
                send(CMD_VEC, $urandom_range(7), src, pick_cost(), i == n_ent - 1);
            if ($urandom_range(3) == 0)
                send(CMD_CHG, $urandom_range(7), $urandom_range(7), pick_cost(), 1'b0);
            if ($urandom_range(2) == 0)
                send(CMD_QRY, $urandom_range(7), $urandom_range(7), pick_cost(),
                     $urandom_range(1));
            if ($urandom_range(5) == 0)
                send(cmd_t'($urandom_range(3)), $urandom_range(7), $urandom_range(7),
                     pick_cost(), $urandom_range(1));
        end
    endtask

    initial
    begin
        int self_id;
        items_sent = 0;
        phases_run = 0;
        calm = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_LINK;
        s_axis_tlast = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: query at reset, table build, saturation, link loss, no-change runs
        send(CMD_QRY, 0, 0, 0, 1'b0);
        set_self(2);
        send(CMD_LINK, 0, 0, 5, 1'b0);
        send(CMD_LINK, 1, 7, 1048575, 1'b0);
        send(CMD_LINK, 7, 0, 1, 1'b0);
        send(CMD_LINK, 2, 0, 3, 1'b1);
        send(CMD_VEC, 3, 7, 2, 1'b0);
        send(CMD_VEC, 4, 7, -1, 1'b0);
        send(CMD_VEC, 3, 1, 1048575, 1'b1);
        send(CMD_VEC, 5, 0, 0, 1'b1);
        send(CMD_VEC, 6, 1, 1048575, 1'b1);
        send(CMD_CHG, 7, 0, 10, 1'b0);
        send(CMD_QRY, 3, 0, 0, 1'b0);
        send(CMD_CHG, 0, 0, -1, 1'b1);
        send(CMD_QRY, 5, 7, -1, 1'b1);
        send(CMD_QRY, 7, 0, 0, 1'b0);
        send(CMD_QRY, 6, 0, 0, 1'b0);
        send(CMD_VEC, 3, 1, 1048575, 1'b1);
        set_self(7);
        send(CMD_LINK, 7, 0, 4, 1'b1);
        send(CMD_QRY, 7, 0, 0, 1'b0);
        set_self(0);
        send(CMD_LINK, 0, 0, 0, 1'b1);

        calm = 1;
        random_phase(0);
        calm = 0;
        random_phase(7);
        while (items_sent < 110)
        begin
            self_id = $urandom_range(7);
            random_phase(self_id);
        end

        settle();
        $display("run covered %0d input beats over %0d router settings", items_sent,
                 phases_run);
        $display("%0d result beats checked", beats_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
